[rtl/clup_pkg.sv]
// Package for the command list unpacker: parser phases, field widths,
// header bit positions and the result structures.
// No dependencies; every other file of the block refers to it.
package clup_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned MaskW  = 4;
  localparam int unsigned CountW = 11;

  // Header field positions.
  localparam int unsigned HdrMaskLsb   = 16;
  localparam int unsigned HdrCountLsb  = 20;
  localparam int unsigned HdrConsecBit = 31;

  // Parser phase: what the next word of the list is expected to be.
  typedef enum logic [1:0] {
    PH_PARAM  = 2'd0,
    PH_HEADER = 2'd1,
    PH_EXTRA  = 2'd2,
    PH_PAD    = 2'd3
  } clup_phase_t;

  // One register write.
  typedef struct packed {
    logic [AddrW-1:0] reg_addr;
    logic [WordW-1:0] reg_value;
    logic [MaskW-1:0] byte_mask;
  } clup_result_t;

  // Write handed from the parser to the output stage.
  typedef struct packed {
    logic         valid;
    clup_result_t result;
  } clup_push_t;

endpackage

[rtl/clup_in_if.sv]
// Input channel of the command list unpacker: one list word per request.
// Depends on clup_pkg for the word width.
interface clup_in_if;
  logic                       valid;
  logic                       ready;
  logic [clup_pkg::WordW-1:0] command_word;
  logic                       last_word;

  modport source (output valid, output command_word, output last_word, input ready);
  modport sink (input valid, input command_word, input last_word, output ready);
endinterface

[rtl/clup_out_if.sv]
// Result channel of the command list unpacker: one register write per request.
// Depends on clup_pkg for the field widths.
interface clup_out_if;
  logic                       valid;
  logic                       ready;
  logic [clup_pkg::AddrW-1:0] reg_addr;
  logic [clup_pkg::WordW-1:0] reg_value;
  logic [clup_pkg::MaskW-1:0] byte_mask;

  modport source (output valid, output reg_addr, output reg_value, output byte_mask,
                  input ready);
  modport sink (input valid, input reg_addr, input reg_value, input byte_mask,
                output ready);
endinterface

[rtl/clup_parser.sv]
// Command list parser: holds the command state and turns each accepted word
// into at most one register write. Depends on clup_pkg.
module clup_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [clup_pkg::WordW-1:0] word,
  input  logic                       last,
  output clup_pkg::clup_push_t       push
);

  clup_pkg::clup_phase_t        phase_r, phase_nxt;
  logic [clup_pkg::WordW-1:0]   held_param_r, held_param_nxt;
  logic [clup_pkg::AddrW-1:0]   target_r, target_nxt;
  logic [clup_pkg::CountW-1:0]  remaining_r, remaining_nxt;
  logic                         consec_r, consec_nxt;
  logic [clup_pkg::MaskW-1:0]   mask_r, mask_nxt;
  logic                         pad_r, pad_nxt;

  logic [clup_pkg::CountW-1:0]  hdr_count;
  logic [clup_pkg::AddrW-1:0]   hdr_addr;
  logic [clup_pkg::MaskW-1:0]   hdr_mask;
  logic [clup_pkg::AddrW-1:0]   extra_addr;
  logic [clup_pkg::CountW-1:0]  remaining_dec;

  // Header fields and the address of the next extra word.
  assign hdr_addr      = word[clup_pkg::AddrW-1:0];
  assign hdr_mask      = word[clup_pkg::HdrMaskLsb +: clup_pkg::MaskW];
  assign hdr_count     = word[clup_pkg::HdrCountLsb +: clup_pkg::CountW];
  assign extra_addr    = consec_r ? target_r + clup_pkg::AddrW'(1) : target_r;
  assign remaining_dec = remaining_r - clup_pkg::CountW'(1);

  // Next state of the command.
  always_comb begin
    phase_nxt      = phase_r;
    held_param_nxt = held_param_r;
    target_nxt     = target_r;
    remaining_nxt  = remaining_r;
    consec_nxt     = consec_r;
    mask_nxt       = mask_r;
    pad_nxt        = pad_r;
    if (accept) begin
      unique case (phase_r)
        clup_pkg::PH_PARAM: begin
          held_param_nxt = word;
          phase_nxt      = clup_pkg::PH_HEADER;
        end
        clup_pkg::PH_HEADER: begin
          target_nxt    = hdr_addr;
          mask_nxt      = hdr_mask;
          consec_nxt    = word[clup_pkg::HdrConsecBit];
          remaining_nxt = hdr_count;
          pad_nxt       = hdr_count[0];
          phase_nxt     = (hdr_count != '0) ? clup_pkg::PH_EXTRA : clup_pkg::PH_PARAM;
        end
        clup_pkg::PH_EXTRA: begin
          target_nxt    = extra_addr;
          remaining_nxt = remaining_dec;
          if (remaining_dec == '0) begin
            phase_nxt = pad_r ? clup_pkg::PH_PAD : clup_pkg::PH_PARAM;
            pad_nxt   = 1'b0;
          end
        end
        clup_pkg::PH_PAD: begin
          phase_nxt = clup_pkg::PH_PARAM;
        end
        default: begin
          phase_nxt = clup_pkg::PH_PARAM;
        end
      endcase
      // The final word of a list drops any partial command.
      if (last) begin
        phase_nxt     = clup_pkg::PH_PARAM;
        remaining_nxt = '0;
        pad_nxt       = 1'b0;
      end
    end
  end

  // Register write caused by the current word.
  always_comb begin
    push.valid            = 1'b0;
    push.result.reg_addr  = target_r;
    push.result.reg_value = word;
    push.result.byte_mask = mask_r;
    unique case (phase_r)
      clup_pkg::PH_HEADER: begin
        push.valid            = accept;
        push.result.reg_addr  = hdr_addr;
        push.result.reg_value = held_param_r;
        push.result.byte_mask = hdr_mask;
      end
      clup_pkg::PH_EXTRA: begin
        push.valid           = accept;
        push.result.reg_addr = extra_addr;
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

  // Control state and the held command fields are all reset alike.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= clup_pkg::PH_PARAM;
      held_param_r <= '0;
      target_r     <= '0;
      remaining_r  <= '0;
      consec_r     <= 1'b0;
      mask_r       <= '0;
      pad_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      held_param_r <= held_param_nxt;
      target_r     <= target_nxt;
      remaining_r  <= remaining_nxt;
      consec_r     <= consec_nxt;
      mask_r       <= mask_nxt;
      pad_r        <= pad_nxt;
    end
  end

  // While extra words are expected, the count of them is never zero.
  a_extra_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == clup_pkg::PH_EXTRA |-> remaining_r != '0)
    else $error("extra phase with zero words remaining");

  // A pad word is only awaited after an odd count of extras.
  a_pad_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == clup_pkg::PH_PAD |-> !pad_r && remaining_r == '0)
    else $error("pad phase with pending state left over");

  // A header with extras leads to the extra phase unless the list ends.
  a_hdr_extra: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !last && phase_r == clup_pkg::PH_HEADER && hdr_count != '0
    |=> phase_r == clup_pkg::PH_EXTRA && remaining_r == $past(hdr_count))
    else $error("header with extras did not enter the extra phase");

  // The final word always returns the parser to the parameter phase.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last |=> phase_r == clup_pkg::PH_PARAM && !pad_r)
    else $error("final word left a partial command");

endmodule

[rtl/clup_out_stage.sv]
// Output stage: a result register backed by one skid register, so that the
// input side keeps running while a write waits. Depends on clup_pkg.
module clup_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  clup_pkg::clup_push_t push,
  output logic                 space,
  clup_out_if.source           out_ch
);

  logic                   main_v_r, main_v_nxt;
  logic                   skid_v_r, skid_v_nxt;
  clup_pkg::clup_result_t main_r, main_nxt;
  clup_pkg::clup_result_t skid_r, skid_nxt;
  logic                   pop;

  assign pop   = main_v_r && out_ch.ready;
  assign space = !skid_v_r;

  // Refill the result register from the skid register first, then from the parser.
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push.valid) begin
      if (!main_v_r || pop) begin
        main_nxt   = push.result;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push.result;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid     = main_v_r;
  assign out_ch.reg_addr  = main_r.reg_addr;
  assign out_ch.reg_value = main_r.reg_value;
  assign out_ch.byte_mask = main_r.byte_mask;

  // The skid register only fills behind a waiting result.
  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid register full while result register empty");

  // A write pushed while the skid register is full would be lost.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> space)
    else $error("write pushed into a full output stage");

  // A stalled result with a full skid register keeps both entries.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ch.ready |=> skid_v_r && main_v_r)
    else $error("output stage dropped a write under stall");

endmodule

[rtl/gpu_command_list_unpacker.sv]
// Top level of the command list unpacker: parser plus output stage.
// Depends on clup_pkg, clup_in_if, clup_out_if, clup_parser and clup_out_stage.
//
//   channel  direction  payload                                per request
//   in_ch    sink       command_word[31:0], last_word          one list word
//   out_ch   source     reg_addr[15:0], reg_value[31:0],       one register write
//                       byte_mask[3:0]
//
// One word is taken per cycle while in_ch.ready is high; a header or extra
// word queues a write in the output stage; parameter and pad words yield none.
// Reset (rst_n low, synchronous) returns the parser to expecting a parameter
// word and empties the output stage.
// in_ch.ready depends only on the skid register: it drops for as long as two
// writes wait on a stalled out_ch, and comes back the cycle after one is taken.
module gpu_command_list_unpacker (
  input  logic        clk,
  input  logic        rst_n,
  clup_in_if.sink     in_ch,
  clup_out_if.source  out_ch
);

  logic                 accept;
  logic                 space;
  clup_pkg::clup_push_t push;

  assign in_ch.ready = space;
  assign accept      = in_ch.valid && space;

  clup_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .word   (in_ch.command_word),
    .last   (in_ch.last_word),
    .push   (push)
  );

  clup_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (space),
    .out_ch (out_ch)
  );

endmodule

[sim/clup_write_checker.sv]
// Checker for the command list unpacker: watches both channels, predicts the
// register writes from the accepted list words and compares them in order.
// Depends on clup_pkg for the field widths, header positions and phases.
module clup_write_checker
  import clup_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [WordW-1:0]  in_word,
  input  logic              in_last,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [AddrW-1:0]  out_addr,
  input  logic [WordW-1:0]  out_value,
  input  logic [MaskW-1:0]  out_mask,
  output int unsigned       mismatches,
  output int unsigned       writes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the parser state.
  clup_phase_t       phase_q;
  logic [WordW-1:0]  param_q;
  logic [AddrW-1:0]  target_q;
  logic [CountW-1:0] remaining_q;
  logic              consec_q;
  logic [MaskW-1:0]  mask_q;
  logic              pad_q;

  clup_result_t      predicted_writes[$];
  int unsigned       fail_total;

  initial begin
    mismatches     = 0;
    writes_pending = 0;
    fail_total     = 0;
  end

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("%0t ns: write mismatch, %s: got 0x%0h, wanted 0x%0h", $realtime, what, got,
             want);
    fail_total++;
  endtask

  // Advance the shadow parser by one list word and queue any write it makes.
  task automatic predict_word(input logic [WordW-1:0] word, input logic last);
    logic [CountW-1:0] extra;
    extra = word[HdrCountLsb +: CountW];
    case (phase_q)
      PH_PARAM: begin
        param_q = word;
        phase_q = PH_HEADER;
      end
      PH_HEADER: begin
        target_q = word[AddrW-1:0];
        mask_q   = word[HdrMaskLsb +: MaskW];
        consec_q = word[HdrConsecBit];
        predicted_writes.push_back('{reg_addr: target_q, reg_value: param_q,
                                     byte_mask: mask_q});
        if (extra != '0) begin
          remaining_q = extra;
          pad_q       = extra[0];
          phase_q     = PH_EXTRA;
        end else begin
          remaining_q = '0;
          pad_q       = 1'b0;
          phase_q     = PH_PARAM;
        end
      end
      PH_EXTRA: begin
        if (consec_q) target_q = target_q + 1'b1;
        predicted_writes.push_back('{reg_addr: target_q, reg_value: word, byte_mask: mask_q});
        remaining_q = remaining_q - 1'b1;
        if (remaining_q == '0) begin
          phase_q = pad_q ? PH_PAD : PH_PARAM;
          pad_q   = 1'b0;
        end
      end
      default: begin
        // A pad word is dropped whatever it holds.
        phase_q = PH_PARAM;
      end
    endcase
    // The final word of a list abandons any command still open.
    if (last) begin
      phase_q     = PH_PARAM;
      remaining_q = '0;
      pad_q       = 1'b0;
    end
  endtask

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    clup_result_t want;
    if (!rst_n) begin
      phase_q     = PH_PARAM;
      param_q     = '0;
      target_q    = '0;
      remaining_q = '0;
      consec_q    = 1'b0;
      mask_q      = '0;
      pad_q       = 1'b0;
      predicted_writes.delete();
    end else begin
      if (in_valid && in_ready) predict_word(in_word, in_last);
      if (out_valid && out_ready) begin
        if (predicted_writes.size() == 0) begin
          report_mismatch("write with none predicted", out_value, '0);
        end else begin
          want = predicted_writes.pop_front();
          if (out_addr != want.reg_addr)
            report_mismatch("reg_addr", out_addr, want.reg_addr);
          if (out_value != want.reg_value)
            report_mismatch("reg_value", out_value, want.reg_value);
          if (out_mask != want.byte_mask)
            report_mismatch("byte_mask", out_mask, want.byte_mask);
        end
      end
    end
    mismatches     <= fail_total;
    writes_pending <= predicted_writes.size();
  end

endmodule

[sim/tb_gpu_command_list_unpacker.sv]
// Testbench top for the command list unpacker: drives list words with random
// gaps and stalls, and gives the verdict from the write checker's count.
// Depends on clup_pkg, clup_in_if, clup_out_if, the block and clup_write_checker.
module tb_gpu_command_list_unpacker;
  import clup_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PhaseWords  = 270;
  localparam int unsigned DrainCycles = 8;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned words_sent;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned writes_pending;

  clup_in_if  in_ch ();
  clup_out_if out_ch ();

  gpu_command_list_unpacker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  clup_write_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_word        (in_ch.command_word),
    .in_last        (in_ch.last_word),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_addr       (out_ch.reg_addr),
    .out_value      (out_ch.reg_value),
    .out_mask       (out_ch.byte_mask),
    .mismatches     (mismatches),
    .writes_pending (writes_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver stalls at random, at the rate of the current phase.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] header_word(input logic consec,
                                                   input logic [CountW-1:0] count,
                                                   input logic [MaskW-1:0] mask,
                                                   input logic [AddrW-1:0] addr);
    return {consec, count, mask, addr};
  endfunction

  // Offer one word, idling first at random, and hold it until it is taken.
  task automatic push_word(input logic [WordW-1:0] word, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command_word <= word;
    in_ch.last_word    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // One command with random content; some end the list early or are stray words.
  task automatic send_random_command();
    logic [WordW-1:0]  param;
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    logic [AddrW-1:0]  addr;
    logic              end_last;
    int unsigned       kind;
    int unsigned       pick;
    int unsigned       n_words;
    int unsigned       abort_at;
    int unsigned       abort_max;
    kind = $urandom_range(99);
    if (kind < 5) begin
      push_word($urandom, 1'($urandom_range(1)));
      return;
    end
    pick = $urandom_range(99);
    if (pick < 60) count = CountW'($urandom_range(4));
    else if (pick < 85) count = CountW'($urandom_range(16, 5));
    else count = CountW'($urandom_range(2047));
    addr = ($urandom_range(3) == 0) ? AddrW'($urandom_range(16'hffff, 16'hfff0))
                                    : AddrW'($urandom);
    pick = $urandom_range(9);
    param = (pick == 0) ? '0 : (pick == 1) ? '1 : WordW'($urandom);
    n_words  = 2 + count + count[0];
    end_last = ($urandom_range(9) == 0);
    abort_at = n_words;
    // Long commands are always cut short by a final word to keep the run brief.
    if (count > 24 || kind < 15) begin
      abort_max = (n_words - 1 < 24) ? n_words - 1 : 24;
      abort_at  = $urandom_range(abort_max);
    end
    for (int unsigned i = 0; i < n_words; i++) begin
      if (i == 0) word = param;
      else if (i == 1)
        word = header_word(1'($urandom_range(1)), count, MaskW'($urandom_range(15)), addr);
      else word = $urandom;
      push_word(word, (i == abort_at) || (i == n_words - 1 && end_last));
      if (i == abort_at) break;
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned phase_start;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command_word = '0;
    in_ch.last_word    = 1'b0;
    send_idle_pct      = 29;
    recv_idle_pct      = 82;
    words_sent         = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes with no extra words.
    push_word('1, 1'b0);
    push_word(header_word(1'b1, '0, '1, '1), 1'b0);
    push_word('0, 1'b0);
    push_word('0, 1'b0);
    // Consecutive writes that wrap the register id, then the pad word.
    push_word(32'h1234_5678, 1'b0);
    push_word(header_word(1'b1, 11'd3, 4'h5, 16'hfffe), 1'b0);
    push_word(32'haaaa_aaaa, 1'b0);
    push_word(32'h5555_5555, 1'b0);
    push_word(32'hdead_beef, 1'b0);
    push_word(32'h0bad_f00d, 1'b0);
    // Non-consecutive extras all go to the header's register.
    push_word(32'h0000_0001, 1'b0);
    push_word(header_word(1'b0, 11'd2, 4'ha, 16'h0100), 1'b0);
    push_word(32'h8000_0000, 1'b0);
    push_word(32'h7fff_ffff, 1'b0);
    // A final word on the header still emits the write but drops the extras.
    push_word(32'hcafe_0000, 1'b0);
    push_word(header_word(1'b1, 11'd3, 4'h3, 16'h0200), 1'b1);
    // Largest extra count, cut short by a final word.
    push_word(32'h0f0f_0f0f, 1'b0);
    push_word(header_word(1'b0, '1, '0, 16'h0300), 1'b0);
    push_word(32'hf0f0_f0f0, 1'b1);
    // A lone parameter that ends the list.
    push_word(32'h1357_9bdf, 1'b1);
    // A pad word of all ones that also ends the list.
    push_word(32'h2468_ace0, 1'b0);
    push_word(header_word(1'b0, 11'd1, 4'hc, 16'h0400), 1'b0);
    push_word(32'h1111_2222, 1'b0);
    push_word('1, 1'b1);

    // Random commands, in three phases of idling.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 29 : (p == 1) ? 82 : 0;
      recv_idle_pct = (p == 0) ? 82 : (p == 1) ? 29 : 0;
      phase_start   = words_sent;
      while (words_sent - phase_start < PhaseWords) send_random_command();
    end
    in_ch.valid <= 1'b0;

    // Let the last request reach the checker, then drain.
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[gpu_command_list_unpacker.f]
rtl/clup_pkg.sv
rtl/clup_in_if.sv
rtl/clup_out_if.sv
rtl/clup_parser.sv
rtl/clup_out_stage.sv
rtl/gpu_command_list_unpacker.sv
sim/clup_write_checker.sv
sim/tb_gpu_command_list_unpacker.sv
